// ----- hw/rtl/iiel_pkg.sv -----
// Shared types and constants for the indexed insert/erase list.
// No dependencies; imported by iiel_cell and indexed_insert_erase_list.
package iiel_pkg;

	localparam int DATA_W      = 32;
	localparam int FUNC_W      = 3;
	localparam int POS_W       = 5;
	localparam int COUNT_OUT_W = 5;
	localparam int STATUS_W    = 2;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 104;

	typedef enum logic [FUNC_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_ERASE  = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What one cell does at the next edge
	typedef enum logic [1:0] {
		CMD_HOLD       = 2'd0,
		CMD_LOAD       = 2'd1,
		CMD_SHIFT_UP   = 2'd2,
		CMD_SHIFT_DOWN = 2'd3
	} cell_cmd_t;

endpackage

// ----- hw/rtl/iiel_cell.sv -----
// One entry cell of the list: holds a word, loads, or takes a neighbor's word.
// Depends on iiel_pkg.
module iiel_cell (
	input  logic                                clk,
	input  iiel_pkg::cell_cmd_t                 cmd,
	input  logic signed [iiel_pkg::DATA_W-1:0] load_word,
	input  logic signed [iiel_pkg::DATA_W-1:0] lower_word,
	input  logic signed [iiel_pkg::DATA_W-1:0] upper_word,
	output logic signed [iiel_pkg::DATA_W-1:0] word
);
	import iiel_pkg::*;

	logic signed [DATA_W-1:0] word_q;

	// payload only, no reset: contents undefined until written
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_HOLD:       word_q <= word_q;
			CMD_LOAD:       word_q <= load_word;
			CMD_SHIFT_UP:   word_q <= lower_word;
			CMD_SHIFT_DOWN: word_q <= upper_word;
			default:        word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

// ----- hw/rtl/indexed_insert_erase_list.sv -----
// Top level of the indexed insert/erase list: control, cell row, result stage.
// Depends on iiel_pkg and iiel_cell.
//
// Bounded ordered list of signed 32-bit words held in a row of DEPTH cells.
// Each request carries an operation (append, insert at position, erase at
// position, read, write) and returns exactly one result with the read word,
// the new count, an empty flag, the first and last entries and a status
// (ok, position out of range, list full). A rejected operation leaves the
// list unchanged. Timing: a request is taken in every cycle while the result
// path keeps moving. At the accepting edge every cell loads, holds, or takes
// its lower or upper neighbor's word, so insert and erase shift the cells
// from the position upward at that edge. From the stage 1 registers, the read
// and back words are picked from the cells by a one-hot select, the front
// word from cell 0, and registered as the result; a stalled result output
// stops intake once the select stage is occupied. Entries are not cleared at
// reset, only the count is: no clearing pass, the block is ready right after
// reset. The count field is 5 bits wide and wraps for DEPTH above 31.
module indexed_insert_erase_list #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [2:0] func, [7:3] position, [39:8] elem_value
	input  logic [iiel_pkg::IN_TDATA_W-1:0]      s_tdata,
	// result channel
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] read_value, [36:32] count, [37] is_empty, [69:38] front_value,
	// [101:70] back_value, [103:102] status
	output logic [iiel_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import iiel_pkg::*;

	// count holds 0..DEPTH; compare width covers both count and position
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	// ---------------- request fields ----------------
	logic [FUNC_W-1:0]        in_func;
	logic [POS_W-1:0]         in_pos;
	logic signed [DATA_W-1:0] in_word;

	assign in_func = s_tdata[2:0];
	assign in_pos  = s_tdata[7:3];
	assign in_word = s_tdata[39:8];

	// ---------------- state ----------------
	logic [CW-1:0] count_q;
	logic          s1_valid_q;
	logic          out_valid_q;

	logic [CW-1:0] count_s1;
	logic [XW-1:0] rd_pos_s1;
	logic          rd_ok_s1;
	status_t       status_s1;

	logic s1_advance;
	logic accept;

	// Result register takes stage 1 whenever it is empty or being drained.
	assign s1_advance = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready   = !s1_valid_q || s1_advance;
	assign accept     = s_tvalid && s_tready;

	// ---------------- operation decode ----------------
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          full;
	logic          do_append, do_insert, do_erase, do_write, do_read;
	status_t       status_d;
	logic [CW-1:0] count_d;

	assign pos_x = XW'(in_pos);
	assign cnt_x = XW'(count_q);
	assign full  = (count_q == CW'(DEPTH));

	always_comb begin
		do_append = 1'b0;
		do_insert = 1'b0;
		do_erase  = 1'b0;
		do_write  = 1'b0;
		do_read   = 1'b0;
		status_d  = ST_OK;
		unique case (in_func)
			OP_APPEND: begin
				if (full) status_d = ST_FULL;
				else      do_append = 1'b1;
			end
			OP_INSERT: begin
				// position check wins over the full check
				if (pos_x > cnt_x) status_d = ST_RANGE;
				else if (full)     status_d = ST_FULL;
				else               do_insert = 1'b1;
			end
			OP_ERASE: begin
				if (pos_x >= cnt_x) status_d = ST_RANGE;
				else                do_erase = 1'b1;
			end
			OP_READ: begin
				if (pos_x >= cnt_x) status_d = ST_RANGE;
				else                do_read = 1'b1;
			end
			OP_WRITE: begin
				if (pos_x >= cnt_x) status_d = ST_RANGE;
				else                do_write = 1'b1;
			end
			default: ;  // unused codes: no change, status ok
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (do_append || do_insert) count_d = count_q + CW'(1);
		else if (do_erase)          count_d = count_q - CW'(1);
	end

	// ---------------- cell row ----------------
	logic signed [DATA_W-1:0] cell_word [DEPTH];
	cell_cmd_t                cell_cmd  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [XW-1:0]            ix;
		logic [XW-1:0]            ix_next;
		logic signed [DATA_W-1:0] lower_w;
		logic signed [DATA_W-1:0] upper_w;

		assign ix      = XW'(i);
		assign ix_next = XW'(i + 1);

		always_comb begin
			cell_cmd[i] = CMD_HOLD;
			if (accept) begin
				priority if (do_insert && ix > pos_x && ix <= cnt_x)
					cell_cmd[i] = CMD_SHIFT_UP;
				else if (((do_insert || do_write) && ix == pos_x) ||
					(do_append && ix == cnt_x))
					cell_cmd[i] = CMD_LOAD;
				else if (do_erase && ix >= pos_x && ix_next < cnt_x)
					cell_cmd[i] = CMD_SHIFT_DOWN;
				else
					cell_cmd[i] = CMD_HOLD;
			end
		end

		// row ends never shift in from outside; tie to own word
		if (i == 0) begin : g_lo_end
			assign lower_w = cell_word[i];
		end else begin : g_lo
			assign lower_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi_end
			assign upper_w = cell_word[i];
		end else begin : g_hi
			assign upper_w = cell_word[i+1];
		end

		iiel_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd[i]),
			.load_word  (in_word),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (cell_word[i])
		);
	end

	// ---------------- stage 1: control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) count_q <= count_d;
			if (accept)          s1_valid_q <= 1'b1;
			else if (s1_advance) s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1  <= count_d;
			rd_pos_s1 <= pos_x;
			rd_ok_s1  <= do_read;
			status_s1 <= status_d;
		end
	end

	// ---------------- stage 2: select from cells ----------------
	// Cells already hold the state after the request in stage 1; the next
	// request may change them at the same edge the result is captured.
	logic [XW-1:0]            back_idx;
	logic signed [DATA_W-1:0] rd_sel;
	logic signed [DATA_W-1:0] back_sel;
	logic                     empty_s1;

	assign back_idx = XW'(count_s1) - XW'(1);
	assign empty_s1 = (count_s1 == '0);

	always_comb begin
		rd_sel   = '0;
		back_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (XW'(i) == rd_pos_s1) rd_sel   = rd_sel | cell_word[i];
			if (XW'(i) == back_idx)  back_sel = back_sel | cell_word[i];
		end
	end

	logic signed [DATA_W-1:0] read_value_q;
	logic [COUNT_OUT_W-1:0]   count_out_q;
	logic                     is_empty_q;
	logic signed [DATA_W-1:0] front_value_q;
	logic signed [DATA_W-1:0] back_value_q;
	status_t                  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (s1_advance)    out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			read_value_q  <= rd_ok_s1 ? rd_sel : '0;
			count_out_q   <= COUNT_OUT_W'(count_s1);
			is_empty_q    <= empty_s1;
			front_value_q <= empty_s1 ? '0 : cell_word[0];
			back_value_q  <= empty_s1 ? '0 : back_sel;
			status_q      <= status_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {status_q, back_value_q, front_value_q, is_empty_q,
		count_out_q, read_value_q};

endmodule
